// File: rtl/core/windowed_peak_valley_finder_defines.svh
// assertion macros shared by the windowed peak and valley finder
`ifndef WINDOWED_PEAK_VALLEY_FINDER_DEFINES_SVH
`define WINDOWED_PEAK_VALLEY_FINDER_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define WPVF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define WPVF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/wpvf_pkg.sv
// types and constants of the windowed peak and valley finder
`timescale 1ns / 1ps
`default_nettype none

package wpvf_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int HW_REG_BITS  = 5;
    localparam int STOP_BITS    = 13;
    localparam int POS_BITS     = 12;
    localparam int COUNT_BITS   = 13;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 13;

    localparam logic [COUNT_BITS-1:0]   COUNT_MAX  = '1;
    localparam logic [HW_REG_BITS-1:0]  HW_RESET   = 5'd10;
    localparam logic [STOP_BITS-1:0]    STOP_RESET = 13'd4086;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_WINDOW = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCAN_STOP   = 1'b1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_value;
        logic                   is_last;
    } t_in;

    typedef struct packed {
        logic [POS_BITS-1:0] valley_position;
        logic [POS_BITS-1:0] peak_position;
    } t_out;

    // per-cell compare flags against the center sample
    typedef struct packed {
        logic gt;
        logic lt;
    } t_cmp;

endpackage

`default_nettype wire

// File: rtl/core/windowed_peak_valley_finder.sv
// top level of the windowed peak and valley finder
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_in_data  (sample, last flag)
//  out     | output    | o_out_valid / i_out_ready| o_out_data (valley, peak)
//  cfg     | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// one item per cycle while not stalled: a row of 2*MAX_HALF_WINDOW+1 cells shifts on every item,
// and the center test then runs on the registered cells, across all cells in parallel
// a result leaves through an output register, loaded when the pending last item finishes
// synchronous active-low reset clears control, counters and tracked positions
// input stalls only when a last item is due while the output register is full and not being taken
`timescale 1ns / 1ps
`default_nettype none
`include "windowed_peak_valley_finder_defines.svh"

module windowed_peak_valley_finder #(
    parameter int MAX_HALF_WINDOW = 16,
    parameter int MAX_SAMPLES     = 4096
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // sample items
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire wpvf_pkg::t_in                        i_in_data,
    // result items
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output wpvf_pkg::t_out                            o_out_data,
    // configuration writes
    input  wire logic                                 i_cfg_we,
    input  wire logic [wpvf_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [wpvf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int HB    = $clog2(MAX_HALF_WINDOW + 1);
    localparam int IB    = $clog2(DEPTH);
    localparam int CW    = wpvf_pkg::COUNT_BITS + 1;
    localparam logic [16:0] MAX_S = 17'(MAX_SAMPLES);

    // configuration registers
    logic [wpvf_pkg::HW_REG_BITS-1:0] r_half_window;
    logic [wpvf_pkg::STOP_BITS-1:0]   r_scan_stop;

    // scan state
    logic [wpvf_pkg::COUNT_BITS-1:0]  r_count;
    logic [wpvf_pkg::POS_BITS-1:0]    r_valley;
    logic [wpvf_pkg::POS_BITS-1:0]    r_peak;

    // item waiting for its center test
    logic                             r_pend_valid;
    logic                             r_pend_last;
    logic                             r_pend_test;
    logic [wpvf_pkg::POS_BITS-1:0]    r_pend_center;

    // output register
    logic                             r_out_valid;
    wpvf_pkg::t_out                   r_out;

    logic [wpvf_pkg::POS_BITS-1:0]    n_valley;
    logic [wpvf_pkg::POS_BITS-1:0]    n_peak;

    // effective window and stop
    logic [HB-1:0]                    w_h;
    logic [wpvf_pkg::STOP_BITS-1:0]   w_stop;

    logic                             w_in_acc;
    logic                             w_stall;
    logic                             w_fire;
    logic [wpvf_pkg::COUNT_BITS-1:0]  w_cnt_inc;
    logic [CW-1:0]                    w_cnt_ext;
    logic [CW-1:0]                    w_first_ctr;
    logic [CW-1:0]                    w_stop_lim;
    logic                             w_test;
    logic [CW-1:0]                    w_center;

    // cell row
    logic [wpvf_pkg::SAMPLE_BITS-1:0] w_val  [DEPTH];
    wpvf_pkg::t_cmp                   w_cmp  [DEPTH];
    logic [DEPTH-1:0]                 w_gt;
    logic [DEPTH-1:0]                 w_lt;
    logic [wpvf_pkg::SAMPLE_BITS-1:0] w_mid;
    logic                             w_is_max;
    logic                             w_is_min;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_window <= wpvf_pkg::HW_RESET;
            r_scan_stop   <= wpvf_pkg::STOP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wpvf_pkg::CFG_HALF_WINDOW: begin
                    r_half_window <= i_cfg_data[wpvf_pkg::HW_REG_BITS-1:0];
                end
                wpvf_pkg::CFG_SCAN_STOP: begin
                    r_scan_stop <= i_cfg_data[wpvf_pkg::STOP_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // half window of zero acts as one, above the maximum as the maximum
    always_comb begin
        if (r_half_window == '0) begin
            w_h = HB'(1);
        end else if (32'(r_half_window) > MAX_HALF_WINDOW) begin
            w_h = HB'(MAX_HALF_WINDOW);
        end else begin
            w_h = HB'(r_half_window);
        end
    end

    assign w_stop = ({4'b0, r_scan_stop} > MAX_S) ? MAX_S[wpvf_pkg::STOP_BITS-1:0]
                                                   : r_scan_stop;

    // ---------------- handshake ----------------
    // a last item can only finish when the output register has room
    assign w_stall    = r_pend_valid && r_pend_last && r_out_valid && !i_out_ready;
    assign w_fire     = r_pend_valid && !w_stall;
    assign o_in_ready = !w_stall;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // ---------------- center scheduling ----------------
    // center c = count - h is tested when h+1 <= c < stop
    assign w_cnt_inc   = (r_count == wpvf_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;
    assign w_cnt_ext   = CW'(w_cnt_inc);
    assign w_first_ctr = (CW'(w_h) << 1) + CW'(1);
    assign w_stop_lim  = CW'(w_stop) + CW'(w_h);
    assign w_test      = (w_cnt_ext >= w_first_ctr) && (w_cnt_ext < w_stop_lim);
    assign w_center    = w_cnt_ext - CW'(w_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count      <= i_in_data.is_last ? '0 : w_cnt_inc;
                r_pend_valid <= 1'b1;
            end else if (w_fire) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pend_last   <= i_in_data.is_last;
            r_pend_test   <= w_test;
            r_pend_center <= w_center[wpvf_pkg::POS_BITS-1:0];
        end
    end

    // ---------------- cell row ----------------
    // cell 0 holds the newest sample, the center sits in cell h
    assign w_mid = w_val[IB'(w_h)];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        wpvf_cell #(
            .IDX (k),
            .HB  (HB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_in_acc),
            .i_prev  ((k == 0) ? i_in_data.sample_value : w_val[(k == 0) ? 0 : k - 1]),
            .i_mid   (w_mid),
            .i_h     (w_h),
            .o_val   (w_val[k]),
            .o_cmp   (w_cmp[k])
        );
        assign w_gt[k] = w_cmp[k].gt;
        assign w_lt[k] = w_cmp[k].lt;
    end

    // no neighbor greater means a peak, no neighbor smaller a valley
    assign w_is_max = !(|w_gt);
    assign w_is_min = !(|w_lt);

    // ---------------- tracking and result ----------------
    always_comb begin
        n_valley = (r_pend_test && w_is_min) ? r_pend_center : r_valley;
        n_peak   = (r_pend_test && w_is_max) ? r_pend_center : r_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valley <= '0;
            r_peak   <= '0;
        end else if (w_fire) begin
            // a finished scan starts the next one from nothing
            r_valley <= r_pend_last ? '0 : n_valley;
            r_peak   <= r_pend_last ? '0 : n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_pend_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_pend_last) begin
            r_out.valley_position <= n_valley;
            r_out.peak_position   <= n_peak;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    `WPVF_ASSERT_NOW(a_out_from_last, $rose(r_out_valid), $past(w_fire && r_pend_last), "result item without a finished last item")
    `WPVF_ASSERT_NEXT(a_scan_restart, w_in_acc && i_in_data.is_last, r_count == '0 && r_pend_last, "scan count not restarted after last item")
    `WPVF_ASSERT_NEXT(a_track_clear, w_fire && r_pend_last, r_valley == '0 && r_peak == '0, "tracked positions not cleared after result")

endmodule

`default_nettype wire

// File: rtl/core/wpvf_cell.sv
// one window cell: holds a sample, shifts it on, compares it with the center
`timescale 1ns / 1ps
`default_nettype none

module wpvf_cell #(
    parameter int IDX = 0,
    parameter int HB  = 5
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_shift,
    input  wire logic [wpvf_pkg::SAMPLE_BITS-1:0] i_prev,
    input  wire logic [wpvf_pkg::SAMPLE_BITS-1:0] i_mid,
    input  wire logic [HB-1:0]                    i_h,
    output logic      [wpvf_pkg::SAMPLE_BITS-1:0] o_val,
    output wpvf_pkg::t_cmp                        o_cmp
);

    logic [wpvf_pkg::SAMPLE_BITS-1:0] r_val;
    logic [HB:0]                      w_lim;
    logic                             w_en;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_prev;
        end
    end

    // cell takes part only inside the window of 2h+1 samples
    assign w_lim = {i_h, 1'b0};
    assign w_en  = ((HB+1)'(IDX) <= w_lim);

    assign o_val     = r_val;
    assign o_cmp.gt  = w_en && (r_val > i_mid);
    assign o_cmp.lt  = w_en && (r_val < i_mid);

endmodule

`default_nettype wire
